[hw/rtl/dct2_block_forward_inverse_macros.svh]
// assertion macros used by the port-level checker
// no dependencies; every macro samples on i_clk and is disabled in reset
`ifndef DCT2_BLOCK_FORWARD_INVERSE_MACROS_SVH
`define DCT2_BLOCK_FORWARD_INVERSE_MACROS_SVH

// same-cycle implication
`define DCT2_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DCT2_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dct2_pkg.sv]
// shared types, constants and cosine tables of the 2d dct block
// no dependencies
package dct2_pkg;

    localparam int DATA_W     = 24;
    localparam int PART_W     = 32;
    localparam int THR_W      = 23;
    localparam int KW         = 6;
    localparam int MAX_ADDR_W = 6;
    localparam int ROWS_DEF   = 8;
    localparam int COLS_DEF   = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

    // cos(pi*k/(2L)) in Q.14, row L-2
    localparam logic [14:0] COS_TAB [0:6][0:8] = '{
        '{15'd16384, 15'd11585, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0},
        '{15'd16384, 15'd14189, 15'd8192, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0},
        '{15'd16384, 15'd15137, 15'd11585, 15'd6270, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0},
        '{15'd16384, 15'd15582, 15'd13255, 15'd9630, 15'd5063, 15'd0, 15'd0, 15'd0, 15'd0},
        '{15'd16384, 15'd15826, 15'd14189, 15'd11585, 15'd8192, 15'd4240, 15'd0, 15'd0,
          15'd0},
        '{15'd16384, 15'd15973, 15'd14761, 15'd12810, 15'd10215, 15'd7109, 15'd3646, 15'd0,
          15'd0},
        '{15'd16384, 15'd16069, 15'd15137, 15'd13623, 15'd11585, 15'd9102, 15'd6270,
          15'd3196, 15'd0}
    };
    localparam logic [14:0] DC_TAB [0:6] = '{15'd11585, 15'd9459, 15'd8192, 15'd7327,
                                             15'd6689, 15'd6193, 15'd5793};
    localparam logic [14:0] AC_TAB [0:6] = '{15'd16384, 15'd13377, 15'd11585, 15'd10362,
                                             15'd9459, 15'd8758, 15'd8192};

    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  last;
        logic                  col;
        logic [MAX_ADDR_W-1:0] dest;
    } t_mac_ctl;

    typedef struct packed {
        logic                  valid;
        logic                  col;
        logic [MAX_ADDR_W-1:0] dest;
        logic [PART_W-1:0]     data;
    } t_mac_wr;

    // signed cosine for angle index k of a length-len transform (k below 4*len)
    function automatic logic signed [15:0] dct2_cos(input int len, input logic [KW-1:0] k);
        int          kk;
        logic [3:0]  j;
        logic        neg;
        logic [15:0] mag;
        kk = int'(k);
        if (kk <= len) begin
            j   = 4'(kk);
            neg = 1'b0;
        end else if (kk <= 2 * len) begin
            j   = 4'(2 * len - kk);
            neg = 1'b1;
        end else if (kk <= 3 * len) begin
            j   = 4'(kk - 2 * len);
            neg = 1'b1;
        end else begin
            j   = 4'(4 * len - kk);
            neg = 1'b0;
        end
        mag = {1'b0, COS_TAB[len-2][j]};
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [15:0] dct2_fac(input int len, input logic dc);
        return dc ? $signed({1'b0, DC_TAB[len-2]}) : $signed({1'b0, AC_TAB[len-2]});
    endfunction

endpackage

[hw/rtl/dct2_if.sv]
// stream interfaces of the 2d dct block: sample input and value output
// depends on dct2_pkg
interface dct2_in_if;
    import dct2_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface dct2_out_if;
    import dct2_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     last;
    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

[hw/rtl/dct2_mac.sv]
// shared multiply-accumulate pipeline: two multiplies, accumulate, round and clamp
// depends on dct2_pkg
module dct2_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dct2_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [dct2_pkg::PART_W-1:0]  i_operand,
    input  logic signed [15:0]                  i_fac,
    input  logic signed [15:0]                  i_cos,
    input  logic                                i_inv,
    input  logic [dct2_pkg::THR_W-1:0]          i_threshold,
    output dct2_pkg::t_mac_wr                   o_wr,
    output logic                                o_busy
);
    import dct2_pkg::*;

    t_mac_ctl           r_ctl2, r_ctl3, r_ctl4;
    logic signed [47:0] r_p1;
    logic signed [15:0] r_cos2;
    logic signed [63:0] r_p2;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_sum;
    logic signed [63:0] acc_in;
    logic signed [63:0] rnd_row, rnd_fwd, sh_inv;
    logic [PART_W-1:0]  row_val;
    logic [DATA_W-1:0]  fwd_val, inv_val, col_val;
    logic [DATA_W:0]    fwd_mag;
    t_mac_wr            r_wr;

    assign acc_in = r_ctl3.first ? r_p2 : r_acc + r_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else begin
            r_ctl2 <= i_ctl;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= '{valid: r_ctl3.valid & r_ctl3.last,
                        first: r_ctl3.first,
                        last:  r_ctl3.last,
                        col:   r_ctl3.col,
                        dest:  r_ctl3.dest};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1   <= i_operand * i_fac;
        r_cos2 <= i_cos;
        r_p2   <= r_p1 * r_cos2;
        if (r_ctl3.valid) begin
            r_acc <= acc_in;
        end
        if (r_ctl3.valid && r_ctl3.last) begin
            r_sum <= acc_in;
        end
    end

    // result formats: row Q.8 sat 32, forward Q.4 sat 24, inverse floor clamp 0..255
    always_comb begin
        rnd_row = (r_sum + 64'sd524288) >>> 20;
        rnd_fwd = (r_sum + 64'sd2147483648) >>> 32;
        sh_inv  = r_sum >>> 40;
        if (rnd_row > 64'sd2147483647) begin
            row_val = 32'h7fff_ffff;
        end else if (rnd_row < -64'sd2147483648) begin
            row_val = 32'h8000_0000;
        end else begin
            row_val = rnd_row[PART_W-1:0];
        end
        if (rnd_fwd > 64'sd8388607) begin
            fwd_val = 24'h7f_ffff;
        end else if (rnd_fwd < -64'sd8388608) begin
            fwd_val = 24'h80_0000;
        end else begin
            fwd_val = rnd_fwd[DATA_W-1:0];
        end
        fwd_mag = fwd_val[DATA_W-1] ? -{1'b1, fwd_val} : {1'b0, fwd_val};
        if (fwd_mag < {2'b00, i_threshold}) begin
            fwd_val = '0;
        end
        if (r_sum < 0) begin
            inv_val = '0;
        end else if (sh_inv > 64'sd255) begin
            inv_val = 24'd255;
        end else begin
            inv_val = sh_inv[DATA_W-1:0];
        end
        col_val = i_inv ? inv_val : fwd_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr.valid <= 1'b0;
        end else begin
            r_wr.valid <= r_ctl4.valid;
        end
        r_wr.col  <= r_ctl4.col;
        r_wr.dest <= r_ctl4.dest;
        r_wr.data <= r_ctl4.col ? {{(PART_W-DATA_W){col_val[DATA_W-1]}}, col_val} : row_val;
    end

    assign o_wr   = r_wr;
    assign o_busy = r_ctl2.valid | r_ctl3.valid | r_ctl4.valid | r_wr.valid;

endmodule

[hw/rtl/dct2_block_forward_inverse.sv]
// 2d orthonormal dct block, forward or inverse: load ROWS*COLS samples (one per cycle), then
// after the last one a row pass of ROWS*COLS*COLS and a column pass of ROWS*COLS*ROWS
// multiply-accumulate terms on one shared mac, each pass followed by a drain of the mac;
// then each value is read from the block store, captured and held on the output until taken.
// synchronous active-low reset clears control, config and valid/last; not data or stores.
module dct2_block_forward_inverse #(
    parameter int ROWS = dct2_pkg::ROWS_DEF,
    parameter int COLS = dct2_pkg::COLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    dct2_in_if.sink                           i_sample_if,
    dct2_out_if.source                        o_value_if,
    input  logic                              i_cfg_we,
    input  logic [dct2_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dct2_pkg::THR_W-1:0]        i_cfg_data
);
    import dct2_pkg::*;

    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);
    localparam int TW     = (RW > CW) ? RW : CW;

    typedef enum logic [2:0] {
        S_LOAD, S_ROW, S_ROW_DRAIN, S_COL, S_COL_DRAIN, S_EM_ISSUE, S_EM_CAP, S_EM_HOLD
    } t_state;

    t_state                    r_state;
    logic [ADDR_W-1:0]         r_load_cnt, r_em_idx;
    logic [RW-1:0]             r_r;
    logic [CW-1:0]             r_c;
    logic [TW-1:0]             r_t;
    logic [KW-1:0]             r_k;
    t_mac_ctl                  r_ctl1;
    logic signed [15:0]        r_fac1, r_cos1;
    logic                      r_direction;
    logic [THR_W-1:0]          r_threshold;
    logic                      r_out_valid, r_out_last;
    logic [DATA_W-1:0]         r_out_value;

    logic [DATA_W-1:0]         r_blk_mem [DEPTH];
    logic [PART_W-1:0]         r_part_mem [DEPTH];
    logic [DATA_W-1:0]         r_blk_rd;
    logic [PART_W-1:0]         r_part_rd;

    logic                      in_xfer, out_xfer, col_pass, inv, t_end, busy, mac_busy;
    logic [TW-1:0]             t_max;
    logic [KW-1:0]             o_cur, n_o, step, q, k_adv;
    logic [KW:0]               k_sum;
    logic [ADDR_W-1:0]         dest, blk_rd_addr, part_rd_addr;
    logic signed [PART_W-1:0]  operand;
    t_mac_wr                   mac_wr;

    assign inv      = r_direction;
    assign col_pass = (r_state == S_COL);
    assign in_xfer  = i_sample_if.valid & i_sample_if.ready;
    assign out_xfer = o_value_if.valid & o_value_if.ready;

    assign t_max = col_pass ? TW'(ROWS - 1) : TW'(COLS - 1);
    assign t_end = (r_t == t_max);
    assign o_cur = col_pass ? KW'(r_r) : KW'(r_c);
    // angle index steps by 2*o (forward) or 2*o+1 (inverse) modulo 4*len
    assign step  = KW'({o_cur, inv});
    assign q     = col_pass ? KW'(4 * ROWS) : KW'(4 * COLS);
    assign k_sum = {1'b0, r_k} + {1'b0, step};
    assign k_adv = (k_sum >= {1'b0, q}) ? KW'(k_sum - {1'b0, q}) : k_sum[KW-1:0];

    always_comb begin
        if (col_pass) begin
            if (r_c == CW'(COLS - 1)) begin
                n_o = (r_r == RW'(ROWS - 1)) ? '0 : KW'(r_r) + KW'(1);
            end else begin
                n_o = KW'(r_r);
            end
        end else begin
            n_o = (r_c == CW'(COLS - 1)) ? '0 : KW'(r_c) + KW'(1);
        end
    end

    assign dest         = ADDR_W'(int'(r_r) * COLS + int'(r_c));
    assign blk_rd_addr  = (r_state == S_ROW) ? ADDR_W'(int'(r_r) * COLS + int'(r_t)) : r_em_idx;
    assign part_rd_addr = ADDR_W'(int'(r_t) * COLS + int'(r_c));

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIRECTION: r_direction <= i_cfg_data[0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // block store: samples on load, column results on the column pass
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && in_xfer) begin
            r_blk_mem[r_load_cnt] <= i_sample_if.sample;
        end else if (mac_wr.valid && mac_wr.col) begin
            r_blk_mem[mac_wr.dest[ADDR_W-1:0]] <= mac_wr.data[DATA_W-1:0];
        end
        r_blk_rd <= r_blk_mem[blk_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mac_wr.valid && !mac_wr.col) begin
            r_part_mem[mac_wr.dest[ADDR_W-1:0]] <= mac_wr.data;
        end
        r_part_rd <= r_part_mem[part_rd_addr];
    end

    // weight for the term being issued, registered alongside the store read
    always_ff @(posedge i_clk) begin
        if (col_pass) begin
            r_cos1 <= dct2_cos(ROWS, r_k);
            r_fac1 <= dct2_fac(ROWS, inv ? (r_t == '0) : (r_r == '0));
        end else begin
            r_cos1 <= dct2_cos(COLS, r_k);
            r_fac1 <= dct2_fac(COLS, inv ? (r_t == '0) : (r_c == '0));
        end
    end

    assign operand = r_ctl1.col ? $signed(r_part_rd)
                                : $signed({{(PART_W-DATA_W){r_blk_rd[DATA_W-1]}}, r_blk_rd});
    assign busy    = r_ctl1.valid | mac_busy;

    dct2_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_ctl1),
        .i_operand   (operand),
        .i_fac       (r_fac1),
        .i_cos       (r_cos1),
        .i_inv       (inv),
        .i_threshold (r_threshold),
        .o_wr        (mac_wr),
        .o_busy      (mac_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_load_cnt  <= '0;
            r_em_idx    <= '0;
            r_r         <= '0;
            r_c         <= '0;
            r_t         <= '0;
            r_k         <= '0;
            r_ctl1      <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_ctl1.valid <= (r_state == S_ROW) || (r_state == S_COL);
            case (r_state)
                S_LOAD: begin
                    if (in_xfer) begin
                        if (r_load_cnt == ADDR_W'(DEPTH - 1)) begin
                            r_load_cnt <= '0;
                            r_state    <= S_ROW;
                            r_r        <= '0;
                            r_c        <= '0;
                            r_t        <= '0;
                            r_k        <= '0;
                        end else begin
                            r_load_cnt <= r_load_cnt + ADDR_W'(1);
                        end
                    end
                end
                S_ROW, S_COL: begin
                    r_ctl1.first <= (r_t == '0);
                    r_ctl1.last  <= t_end;
                    r_ctl1.col   <= col_pass;
                    r_ctl1.dest  <= MAX_ADDR_W'(dest);
                    if (t_end) begin
                        r_t <= '0;
                        r_k <= inv ? '0 : n_o;
                        if (r_c == CW'(COLS - 1)) begin
                            r_c <= '0;
                            if (r_r == RW'(ROWS - 1)) begin
                                r_r     <= '0;
                                r_state <= col_pass ? S_COL_DRAIN : S_ROW_DRAIN;
                            end else begin
                                r_r <= r_r + RW'(1);
                            end
                        end else begin
                            r_c <= r_c + CW'(1);
                        end
                    end else begin
                        r_t <= r_t + TW'(1);
                        r_k <= k_adv;
                    end
                end
                S_ROW_DRAIN: begin
                    if (!busy) begin
                        r_state <= S_COL;
                        r_k     <= '0;
                    end
                end
                S_COL_DRAIN: begin
                    if (!busy) begin
                        r_state  <= S_EM_ISSUE;
                        r_em_idx <= '0;
                    end
                end
                S_EM_ISSUE: begin
                    r_state <= S_EM_CAP;
                end
                S_EM_CAP: begin
                    r_out_value <= r_blk_rd;
                    r_out_last  <= (r_em_idx == ADDR_W'(DEPTH - 1));
                    r_out_valid <= 1'b1;
                    r_state     <= S_EM_HOLD;
                end
                S_EM_HOLD: begin
                    if (out_xfer) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_em_idx <= '0;
                            r_state  <= S_LOAD;
                        end else begin
                            r_em_idx <= r_em_idx + ADDR_W'(1);
                            r_state  <= S_EM_ISSUE;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign i_sample_if.ready = (r_state == S_LOAD);
    assign o_value_if.valid  = r_out_valid;
    assign o_value_if.value  = r_out_value;
    assign o_value_if.last   = r_out_last;

endmodule

[hw/rtl/dct2_chk.sv]
// port-level checker for the 2d dct block, bound to the top level
// depends on dct2_pkg and the assertion macro header
`include "dct2_block_forward_inverse_macros.svh"

module dct2_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [dct2_pkg::DATA_W-1:0]       i_out_value,
    input logic                              i_out_last
);
    import dct2_pkg::*;

    logic              out_xfer;
    logic              out_stall;
    logic [DATA_W:0]   out_word;
    assign out_xfer  = i_out_valid & i_out_ready;
    assign out_stall = i_out_valid & !i_out_ready;
    assign out_word  = {i_out_last, i_out_value};

    // loading and emitting never overlap
    `DCT2_ASSERT_NOW(a_no_overlap, i_out_valid, !i_in_ready, "input ready while a result is shown")
    // a stalled result holds
    `DCT2_ASSERT_NEXT(a_hold, out_stall, i_out_valid && $stable(out_word), "stalled result changed")
    // the block ends after its last transfer
    `DCT2_ASSERT_NEXT(a_end, out_xfer && i_out_last, !i_out_valid && i_in_ready, "no load after last")
    // mid-block transfers keep the input closed
    `DCT2_ASSERT_NEXT(a_mid, out_xfer && !i_out_last, !i_in_ready, "input opened mid-block")

endmodule

bind dct2_block_forward_inverse dct2_chk u_dct2_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_sample_if.ready),
    .i_out_valid (o_value_if.valid),
    .i_out_ready (o_value_if.ready),
    .i_out_value (o_value_if.value),
    .i_out_last  (o_value_if.last)
);
